@@ hw/rtl/assert_macros.svh @@
// assertion macros for the rtl files
// no dependencies; include by bare file name
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked property, disabled while the active-low reset is asserted
`define GFLT_ASSERT(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) prop) else $error(msg);

// clocked property checked at every edge, reset included
`define GFLT_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ hw/rtl/gflt_pkg.sv @@
// shared types and codes of the GF(2^m) log/antilog table unit
// no dependencies
`default_nettype none

package gflt_pkg;

    // operation selector carried on s_tuser
    typedef enum logic [2:0] {
        ACT_BUILD    = 3'd0,
        ACT_MULTIPLY = 3'd1,
        ACT_INVERSE  = 3'd2,
        ACT_SQUARE   = 3'd3,
        ACT_POWER    = 3'd4
    } action_t;

    // result status carried on m_tuser
    typedef enum logic [1:0] {
        ST_OK            = 2'd0,
        ST_NOT_PRIMITIVE = 2'd1,
        ST_NOT_READY     = 2'd2
    } status_t;

    // configuration register indexes
    localparam logic [1:0] CFG_DEGREE     = 2'd0;
    localparam logic [1:0] CFG_POLYNOMIAL = 2'd1;

    // register reset values
    localparam logic [3:0] DEGREE_RESET     = 4'd8;
    localparam logic [8:0] POLYNOMIAL_RESET = 9'h11D;

endpackage

`default_nettype wire

@@ hw/rtl/galois_field_log_table_alu.sv @@
// Usage notes for galois_field_log_table_alu
// GF(2^m) arithmetic unit with log and antilog tables in two synchronous memories.
// Channels: s_* takes one operation per transfer (action on s_tuser, operands and
//   exponent on s_tdata); m_* returns one result per operation (value on m_tdata,
//   status on m_tuser); cfg_* writes field_degree (index 0) or field_polynomial
//   (index 1), and any such write drops the tables-ready flag.
// Operations run one at a time. States from input transfer to the output register:
//   trivial (not ready, zero operand or exponent, unknown action, bad degree): done
//   multiply, inverse, square: log read, index add, antilog read, done
//   power: log read, load, one loop step per exponent bit up to the highest set bit,
//     antilog read, done; the loop adds logs modulo 2^m-1 without touching the memories
//   build: walk writing one table entry pair per cycle, wraparound entry, done
// s_tready is high only between operations; the next item is taken in the cycle after
// the previous result is loaded into the output register, while it still waits
// there, so a new operation is never taken before the last result is handed over.
// When the receiver stalls, the finished result waits in its state until the
// output register is free, so nothing is lost.
// Reset restores degree 8 and polynomial 0x11D and clears the ready flag; the
// tables are not cleared and must be built before arithmetic returns status ok.
// Depends on gflt_pkg and assert_macros.svh.
`default_nettype none

`include "assert_macros.svh"

module galois_field_log_table_alu #(
    parameter int MAX_DEGREE = 8
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // operation channel
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [47:0] s_tdata,   // operand_a[7:0], operand_b[15:8], exponent[47:16]
    input  wire logic [2:0]  s_tuser,   // action[2:0]
    // result channel
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [7:0]       m_tdata,   // value[7:0]
    output logic [1:0]       m_tuser,   // status[1:0]
    // configuration write channel
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [8:0]  cfg_data
);

    localparam int EW    = MAX_DEGREE;
    localparam int DEPTH = 1 << EW;

    typedef enum logic [3:0] {
        S_IDLE,
        S_WALK,
        S_WRAP,
        S_LOG,
        S_ADD,
        S_PLOAD,
        S_POW,
        S_ALOG,
        S_DONE
    } state_t;

    // table memories
    logic [EW-1:0] log_mem  [DEPTH];
    logic [EW-1:0] alog_mem [DEPTH];

    state_t              state_reg;
    logic [3:0]          degree_reg;
    logic [8:0]          poly_reg;
    logic                ready_reg;
    gflt_pkg::action_t   act_reg;
    logic [EW-1:0]       op_a_reg;
    logic [EW-1:0]       op_b_reg;
    logic [31:0]         exp_reg;
    logic [EW-1:0]       x_reg;
    logic [EW-1:0]       i_reg;
    logic                early_reg;
    logic [EW-1:0]       lacc_reg;
    logic [EW-1:0]       lbase_reg;
    logic [7:0]          res_value_reg;
    gflt_pkg::status_t   res_status_reg;
    logic                out_valid_reg;
    logic [7:0]          out_value_reg;
    gflt_pkg::status_t   out_status_reg;

    logic [EW-1:0]       log_rd_a_q;
    logic [EW-1:0]       log_rd_b_q;
    logic [EW-1:0]       alog_rd_q;

    logic [EW-1:0]       mask;
    logic [EW:0]         deg_onehot;
    logic [EW:0]         x_shift;
    logic [EW:0]         x_reduced;
    logic [EW-1:0]       x_next;
    logic [EW-1:0]       a_in;
    logic [EW-1:0]       b_in;
    logic [EW-1:0]       mul_idx;
    logic [EW-1:0]       idx_calc;
    logic [EW-1:0]       lacc_next;
    logic [EW-1:0]       lbase_next;
    logic [EW-1:0]       alog_addr;
    logic                log_we;
    logic                alog_we;
    logic [EW-1:0]       alog_waddr;
    logic [EW-1:0]       alog_wdata;
    logic                degree_bad;
    logic                in_xfer;
    logic                cfg_xfer;
    logic                out_free;
    state_t              issue_state;
    logic [7:0]          issue_value;
    gflt_pkg::status_t   issue_status;

    // modular add of two logarithms below the group order
    function automatic logic [EW-1:0] add_mod(input logic [EW-1:0] x,
                                              input logic [EW-1:0] y,
                                              input logic [EW-1:0] order);
        logic [EW:0] sum;
        sum = {1'b0, x} + {1'b0, y};
        if (sum >= {1'b0, order}) begin
            sum = sum - {1'b0, order};
        end
        return sum[EW-1:0];
    endfunction

    // element mask 2^m-1 (also the group order) and one-hot of bit m
    always_comb begin
        for (int k = 0; k < EW; k++) begin
            mask[k] = (k < int'(degree_reg));
        end
        for (int k = 0; k <= EW; k++) begin
            deg_onehot[k] = (k == int'(degree_reg));
        end
    end

    assign degree_bad = (degree_reg < 4'd2) || (int'(degree_reg) > MAX_DEGREE);

    // multiply the walk element by x and reduce
    always_comb begin
        x_shift   = {x_reg, 1'b0};
        x_reduced = (|(x_shift & deg_onehot)) ? (x_shift ^ (EW+1)'(poly_reg)) : x_shift;
        x_next    = x_reduced[EW-1:0] & mask;
    end

    // masked operands
    assign a_in = EW'(s_tdata[7:0]) & mask;
    assign b_in = EW'(s_tdata[15:8]) & mask;

    // antilog index for the table operations
    assign mul_idx = add_mod(log_rd_a_q,
                             (act_reg == gflt_pkg::ACT_MULTIPLY) ? log_rd_b_q : log_rd_a_q,
                             mask);
    assign idx_calc = (act_reg == gflt_pkg::ACT_INVERSE) ? (mask - log_rd_a_q) : mul_idx;

    // square-and-multiply step in the log domain
    assign lacc_next  = exp_reg[0] ? add_mod(lacc_reg, lbase_reg, mask) : lacc_reg;
    assign lbase_next = add_mod(lbase_reg, lbase_reg, mask);

    assign alog_addr = (state_reg == S_POW) ? lacc_reg : idx_calc;

    // table write controls during a build
    assign log_we     = (state_reg == S_WALK);
    assign alog_we    = (state_reg == S_WALK) || (state_reg == S_WRAP);
    assign alog_waddr = (state_reg == S_WRAP) ? mask : i_reg;
    assign alog_wdata = (state_reg == S_WRAP) ? EW'(1) : x_reg;

    // log table: one write port, two read ports
    always_ff @(posedge aclk) begin
        if (log_we) begin
            log_mem[x_reg] <= i_reg;
        end
        log_rd_a_q <= log_mem[op_a_reg];
        log_rd_b_q <= log_mem[op_b_reg];
    end

    // antilog table: one write port, one read port
    always_ff @(posedge aclk) begin
        if (alog_we) begin
            alog_mem[alog_waddr] <= alog_wdata;
        end
        alog_rd_q <= alog_mem[alog_addr];
    end

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_xfer   = s_tvalid && s_tready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_free  = !out_valid_reg || m_tready;

    // first state and early result of an accepted operation
    always_comb begin
        issue_state  = S_DONE;
        issue_value  = 8'd0;
        issue_status = gflt_pkg::ST_OK;
        case (gflt_pkg::action_t'(s_tuser))
            gflt_pkg::ACT_BUILD: begin
                if (degree_bad) begin
                    issue_status = gflt_pkg::ST_NOT_PRIMITIVE;
                end else begin
                    issue_state = S_WALK;
                end
            end
            gflt_pkg::ACT_MULTIPLY: begin
                if (!ready_reg) begin
                    issue_status = gflt_pkg::ST_NOT_READY;
                end else if (a_in != '0 && b_in != '0) begin
                    issue_state = S_LOG;
                end
            end
            gflt_pkg::ACT_INVERSE, gflt_pkg::ACT_SQUARE: begin
                if (!ready_reg) begin
                    issue_status = gflt_pkg::ST_NOT_READY;
                end else if (a_in != '0) begin
                    issue_state = S_LOG;
                end
            end
            gflt_pkg::ACT_POWER: begin
                if (!ready_reg) begin
                    issue_status = gflt_pkg::ST_NOT_READY;
                end else if (s_tdata[47:16] == 32'd0) begin
                    issue_value = 8'd1;
                end else if (a_in != '0) begin
                    issue_state = S_LOG;
                end
            end
            default: begin
            end
        endcase
    end

    // tables-ready flag: dropped by a register write or a new build, set by a primitive walk
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ready_reg <= 1'b0;
        end else if (cfg_xfer && (cfg_index == gflt_pkg::CFG_DEGREE ||
                                  cfg_index == gflt_pkg::CFG_POLYNOMIAL)) begin
            ready_reg <= 1'b0;
        end else if (in_xfer && gflt_pkg::action_t'(s_tuser) == gflt_pkg::ACT_BUILD) begin
            ready_reg <= 1'b0;
        end else if (state_reg == S_WRAP && !early_reg && x_reg == EW'(1)) begin
            ready_reg <= 1'b1;
        end
    end

    // control sequencer and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_IDLE;
            degree_reg    <= gflt_pkg::DEGREE_RESET;
            poly_reg      <= gflt_pkg::POLYNOMIAL_RESET;
            out_valid_reg <= 1'b0;
        end else begin
            // output register: load a finished result, drain on a transfer
            if (state_reg == S_DONE && out_free) begin
                out_valid_reg  <= 1'b1;
                out_value_reg  <= res_value_reg;
                out_status_reg <= res_status_reg;
            end else if (out_valid_reg && m_tready) begin
                out_valid_reg <= 1'b0;
            end

            // configuration writes
            if (cfg_xfer) begin
                case (cfg_index)
                    gflt_pkg::CFG_DEGREE: begin
                        degree_reg <= cfg_data[3:0];
                    end
                    gflt_pkg::CFG_POLYNOMIAL: begin
                        poly_reg <= cfg_data;
                    end
                    default: begin
                    end
                endcase
            end

            case (state_reg)
                S_IDLE: begin
                    if (in_xfer) begin
                        act_reg        <= gflt_pkg::action_t'(s_tuser);
                        op_a_reg       <= a_in;
                        op_b_reg       <= b_in;
                        exp_reg        <= s_tdata[47:16];
                        x_reg          <= EW'(1);
                        i_reg          <= '0;
                        early_reg      <= 1'b0;
                        res_value_reg  <= issue_value;
                        res_status_reg <= issue_status;
                        state_reg      <= issue_state;
                    end
                end
                // one table entry pair per cycle along the powers of x
                S_WALK: begin
                    if (i_reg != '0 && x_reg == EW'(1)) begin
                        early_reg <= 1'b1;
                    end
                    x_reg <= x_next;
                    i_reg <= i_reg + EW'(1);
                    if (i_reg == mask - EW'(1)) begin
                        state_reg <= S_WRAP;
                    end
                end
                // wraparound antilog entry and primitivity verdict
                S_WRAP: begin
                    if (early_reg || x_reg != EW'(1)) begin
                        res_status_reg <= gflt_pkg::ST_NOT_PRIMITIVE;
                    end
                    state_reg <= S_DONE;
                end
                // log reads in flight
                S_LOG: begin
                    state_reg <= (act_reg == gflt_pkg::ACT_POWER) ? S_PLOAD : S_ADD;
                end
                // antilog read issued at the combined index
                S_ADD: begin
                    state_reg <= S_ALOG;
                end
                S_PLOAD: begin
                    lacc_reg  <= '0;
                    lbase_reg <= log_rd_a_q;
                    state_reg <= S_POW;
                end
                // one exponent bit per cycle; antilog read issued when done
                S_POW: begin
                    if (exp_reg == 32'd0) begin
                        state_reg <= S_ALOG;
                    end else begin
                        lacc_reg  <= lacc_next;
                        lbase_reg <= lbase_next;
                        exp_reg   <= {1'b0, exp_reg[31:1]};
                    end
                end
                S_ALOG: begin
                    res_value_reg <= 8'(alog_rd_q);
                    state_reg     <= S_DONE;
                end
                // hand the result to the output register once it is free
                S_DONE: begin
                    if (out_free) begin
                        state_reg <= S_IDLE;
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_value_reg;
    assign m_tuser  = out_status_reg;

    // checks on the sequencer
    `GFLT_ASSERT(a_cfg_clears_ready, aclk, aresetn, (cfg_xfer && (cfg_index == gflt_pkg::CFG_DEGREE || cfg_index == gflt_pkg::CFG_POLYNOMIAL)) |=> !ready_reg, "config write did not clear ready flag")
    `GFLT_ASSERT(a_ready_from_build, aclk, aresetn, $rose(ready_reg) |-> $past(state_reg == S_WRAP), "ready flag set outside a build")
    `GFLT_ASSERT(a_walk_in_range, aclk, aresetn, (state_reg == S_WALK) |-> (i_reg < mask), "build walk ran past the group order")
    `GFLT_ASSERT(a_done_holds, aclk, aresetn, (state_reg == S_DONE && out_valid_reg && !m_tready) |=> (state_reg == S_DONE), "result dropped while output stalled")

endmodule

`default_nettype wire
